/* rtl/rc_pulse_capture_calibrate_core_macros.svh */
// assertion macros for the rc pulse capture calibrate core
// used by the top level only, no other dependencies
`ifndef RC_PULSE_CAPTURE_CALIBRATE_CORE_MACROS_SVH
`define RC_PULSE_CAPTURE_CALIBRATE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define RCPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RCPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/rcpc_pkg.sv */
// shared constants for the rc pulse capture calibrate core
// no dependencies
`default_nettype none

package rcpc_pkg;

    localparam int CAL_W      = 37;
    localparam int BOUND_W    = 12;
    localparam int PIN_W      = 6;
    localparam int TS_W       = 32;
    localparam int CHAN_W     = 3;
    localparam int STICK_W    = 11;
    localparam int QUOT_W     = 9;
    localparam int PROD_W     = 21;
    localparam int NUM_REGS   = 6;
    localparam int MAX_CH     = 8;
    localparam int REG_IDX_W  = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    // calibration field positions
    localparam int CAL_LOW_LSB    = 0;
    localparam int CAL_CENTER_LSB = 12;
    localparam int CAL_HIGH_LSB   = 24;
    localparam int CAL_REV_BIT    = 36;

    localparam logic [STICK_W-1:0] STICK_CENTER = 11'd1500;
    localparam logic [QUOT_W-1:0]  STICK_SPAN   = 9'd500;
    localparam logic [TS_W-1:0]    WRAP_LIMIT   = 32'd3000;
    localparam logic [TS_W-1:0]    WRAP_OFFSET  = 32'd20000;

    // reset calibration per channel; channels past the register set use the default
    localparam logic [CAL_W-1:0] CAL_RESET [MAX_CH] = '{
        37'd33728349160, 37'd102380717032, 37'd33728349160,
        37'd33560576995, 37'd33560794127,  37'd33829102596,
        37'd33560576984, 37'd33560576984
    };

endpackage

`default_nettype wire

/* rtl/rc_pulse_capture_calibrate_core.sv */
// rc pulse capture and stick calibration, top level
// depends on rcpc_pkg and rc_pulse_capture_calibrate_core_macros.svh
`default_nettype none

// channel     dir  beat contents (lsb first)
// s_axis      in   tdata: pin_levels[5:0], timestamp_us[37:6], zero pad
// m_axis      out  tdata: channel[2:0], pulse_width[34:3], stick_value[45:35],
//                  zero pad; tlast: last result of the sample
// cfg         in   cfg_we, cfg_index (register 0..5), cfg_data (37 bits)
//
// an input beat is taken while idle; rises and falls update all channels at once
// each falling channel then runs through the sequencer, which scans the channel
// index and then takes width, wrap adjust, compare, span, multiply, 9 divider
// steps, emit; multiply and divide are skipped when the span settles the result
// the restoring divider produces one quotient bit per cycle
// s_axis_tready is low from an accepted beat with a falling channel until its last
// result is loaded into the output register; a stalled m_axis holds the sequencer in emit
// reset clears the channel state and loads the default calibration

`include "rc_pulse_capture_calibrate_core_macros.svh"

module rc_pulse_capture_calibrate_core #(
    parameter int CHANNELS = 6
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // pin_levels[5:0], timestamp_us[37:6], pad
    input  wire logic [rcpc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // channel[2:0], pulse_width[34:3], stick_value[45:35], pad
    output logic      [rcpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic                                  m_axis_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [rcpc_pkg::REG_IDX_W-1:0]   cfg_index,
    input  wire logic [rcpc_pkg::CAL_W-1:0]       cfg_data
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADJ,
        ST_CMP,
        ST_SPAN,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t state_reg;

    // per-channel capture state
    logic [CHANNELS-1:0]             active_reg;
    logic [rcpc_pkg::TS_W-1:0]       rise_reg [CHANNELS];
    logic [CHANNELS-1:0]             pend_reg;
    logic [rcpc_pkg::TS_W-1:0]       ts_reg;
    logic [IDX_W-1:0]                idx_reg;

    // datapath registers
    logic [rcpc_pkg::TS_W-1:0]       width_reg;
    logic signed [rcpc_pkg::TS_W-1:0] actual_reg;
    logic                            below_reg;
    logic                            above_reg;
    logic                            beyond_reg;
    logic                            up_reg;
    logic [rcpc_pkg::BOUND_W-1:0]    num_reg;
    logic [rcpc_pkg::BOUND_W-1:0]    den_reg;
    logic [rcpc_pkg::PROD_W-1:0]     rem_reg;
    logic [rcpc_pkg::PROD_W-1:0]     dvs_reg;
    logic [rcpc_pkg::QUOT_W-1:0]     q_reg;
    logic [3:0]                      cnt_reg;

    // output register
    logic                            out_valid_reg;
    logic                            out_last_reg;
    logic [rcpc_pkg::CHAN_W-1:0]     out_chan_reg;
    logic [rcpc_pkg::TS_W-1:0]       out_width_reg;
    logic [rcpc_pkg::STICK_W-1:0]    out_stick_reg;

    // calibration registers, channels past the register set stay at the default
    logic [rcpc_pkg::CAL_W-1:0]      cal [CHANNELS];
    logic [CHANNELS-1:0]             pins;

    for (genvar k = 0; k < CHANNELS; k++)
    begin : g_chan
        if (k < rcpc_pkg::NUM_REGS)
        begin : g_reg
            logic [rcpc_pkg::CAL_W-1:0] cal_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    cal_reg <= rcpc_pkg::CAL_RESET[k];
                end
                else if (cfg_we && (cfg_index == rcpc_pkg::REG_IDX_W'(k)))
                begin
                    cal_reg <= cfg_data;
                end
            end
            assign cal[k]  = cal_reg;
            assign pins[k] = s_axis_tdata[k];
        end
        else
        begin : g_fixed
            assign cal[k]  = rcpc_pkg::CAL_RESET[k];
            // no pin exists for this channel
            assign pins[k] = 1'b0;
        end
    end

    // fields of the selected channel's calibration
    logic [rcpc_pkg::CAL_W-1:0]     cal_sel;
    logic [rcpc_pkg::BOUND_W-1:0]   low_f;
    logic [rcpc_pkg::BOUND_W-1:0]   center_f;
    logic [rcpc_pkg::BOUND_W-1:0]   high_f;
    logic                           rev_f;
    logic signed [rcpc_pkg::TS_W-1:0] low_s;
    logic signed [rcpc_pkg::TS_W-1:0] center_s;
    logic signed [rcpc_pkg::TS_W-1:0] high_s;

    assign cal_sel  = cal[idx_reg];
    assign low_f    = cal_sel[rcpc_pkg::CAL_LOW_LSB +: rcpc_pkg::BOUND_W];
    assign center_f = cal_sel[rcpc_pkg::CAL_CENTER_LSB +: rcpc_pkg::BOUND_W];
    assign high_f   = cal_sel[rcpc_pkg::CAL_HIGH_LSB +: rcpc_pkg::BOUND_W];
    assign rev_f    = cal_sel[rcpc_pkg::CAL_REV_BIT];
    assign low_s    = signed'({20'd0, low_f});
    assign center_s = signed'({20'd0, center_f});
    assign high_s   = signed'({20'd0, high_f});

    // handshake and misc combinational terms
    logic                         in_take;
    logic                         out_free;
    logic                         out_load;
    logic [CHANNELS-1:0]          fall_mask;
    logic [CHANNELS-1:0]          rest_mask;
    logic                         div_ge;
    logic [rcpc_pkg::STICK_W-1:0] stick_val;
    logic [rcpc_pkg::CHAN_W-1:0]  chan_code;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (state_reg == ST_EMIT) && out_free;
    assign fall_mask     = active_reg & ~pins;
    assign rest_mask     = pend_reg & ~(CHANNELS'(1) << idx_reg);
    assign div_ge        = (rem_reg >= dvs_reg);
    assign stick_val     = up_reg ? (rcpc_pkg::STICK_CENTER + {2'b0, q_reg})
                                  : (rcpc_pkg::STICK_CENTER - {2'b0, q_reg});
    // channel 8 wraps to code 0
    assign chan_code     = rcpc_pkg::CHAN_W'(32'(idx_reg) + 32'd1);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_stick_reg, out_width_reg, out_chan_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            pend_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            for (int k = 0; k < CHANNELS; k++)
            begin
                rise_reg[k] <= '0;
            end
        end
        else
        begin
            // output beat loaded from emit, dropped once it is taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        // rises and falls for every channel at once
                        for (int k = 0; k < CHANNELS; k++)
                        begin
                            if (pins[k] && !active_reg[k])
                            begin
                                rise_reg[k] <= s_axis_tdata[rcpc_pkg::PIN_W +: rcpc_pkg::TS_W];
                            end
                        end
                        active_reg <= pins;
                        pend_reg   <= fall_mask;
                        ts_reg     <= s_axis_tdata[rcpc_pkg::PIN_W +: rcpc_pkg::TS_W];
                        idx_reg    <= '0;
                        if (fall_mask != '0)
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (pend_reg[idx_reg])
                    begin
                        width_reg <= ts_reg - rise_reg[idx_reg];
                        state_reg <= ST_ADJ;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end

                ST_ADJ:
                begin
                    // wide positive widths fold down by the frame offset
                    if (!width_reg[rcpc_pkg::TS_W-1] && (width_reg > rcpc_pkg::WRAP_LIMIT))
                    begin
                        actual_reg <= signed'(width_reg - rcpc_pkg::WRAP_OFFSET);
                    end
                    else
                    begin
                        actual_reg <= signed'(width_reg);
                    end
                    state_reg <= ST_CMP;
                end

                ST_CMP:
                begin
                    below_reg  <= (actual_reg < center_s);
                    above_reg  <= (actual_reg > center_s);
                    beyond_reg <= (actual_reg < center_s) ? (actual_reg < low_s)
                                                          : (actual_reg > high_s);
                    state_reg  <= ST_SPAN;
                end

                ST_SPAN:
                begin
                    up_reg <= above_reg ^ rev_f;
                    priority if (!below_reg && !above_reg)
                    begin
                        // width on the center
                        q_reg     <= '0;
                        state_reg <= ST_EMIT;
                    end
                    else if (below_reg && (low_f > center_f))
                    begin
                        // inverted bound gives full deflection
                        q_reg     <= rcpc_pkg::STICK_SPAN;
                        state_reg <= ST_EMIT;
                    end
                    else if (above_reg && (high_f < center_f))
                    begin
                        q_reg     <= rcpc_pkg::STICK_SPAN;
                        state_reg <= ST_EMIT;
                    end
                    else if (below_reg)
                    begin
                        den_reg   <= center_f - low_f;
                        num_reg   <= beyond_reg ? (center_f - low_f)
                                                : (center_f - actual_reg[rcpc_pkg::BOUND_W-1:0]);
                        q_reg     <= '0;
                        state_reg <= (center_f == low_f) ? ST_EMIT : ST_MUL;
                    end
                    else
                    begin
                        den_reg   <= high_f - center_f;
                        num_reg   <= beyond_reg ? (high_f - center_f)
                                                : (actual_reg[rcpc_pkg::BOUND_W-1:0] - center_f);
                        q_reg     <= '0;
                        state_reg <= (high_f == center_f) ? ST_EMIT : ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    rem_reg   <= rcpc_pkg::PROD_W'(num_reg) *
                                 rcpc_pkg::PROD_W'(rcpc_pkg::STICK_SPAN);
                    dvs_reg   <= {1'b0, den_reg, 8'd0};
                    cnt_reg   <= 4'(rcpc_pkg::QUOT_W - 1);
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    // restoring divide, quotient below 512 since num <= den
                    if (div_ge)
                    begin
                        rem_reg <= rem_reg - dvs_reg;
                    end
                    q_reg   <= {q_reg[rcpc_pkg::QUOT_W-2:0], div_ge};
                    dvs_reg <= dvs_reg >> 1;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == 4'd0)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_last_reg  <= (rest_mask == '0);
                        out_chan_reg  <= chan_code;
                        out_width_reg <= width_reg;
                        out_stick_reg <= stick_val;
                        pend_reg      <= rest_mask;
                        idx_reg       <= idx_reg + 1'b1;
                        state_reg     <= (rest_mask == '0) ? ST_IDLE : ST_SCAN;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // terms for the checks below
    logic stick_ok;
    logic final_load;
    logic drained;

    assign stick_ok   = (out_stick_reg >= 11'd1000) && (out_stick_reg <= 11'd2000);
    assign final_load = out_load && (rest_mask == '0);
    assign drained    = (state_reg == ST_IDLE) && (pend_reg == '0) && out_last_reg;

    // calibrated value never leaves the stick range
    `RCPC_ASSERT_NOW(a_stick_range, out_valid_reg, stick_ok, "stick value out of range")
    // deflection never exceeds the half span when a result is formed
    `RCPC_ASSERT_NOW(a_quot_bound, state_reg == ST_EMIT, q_reg <= rcpc_pkg::STICK_SPAN, "deflection above half span")
    // a final beat leaves no pending channel behind
    `RCPC_ASSERT_NEXT(a_last_drains, final_load, drained, "last beat with channels pending")

endmodule

`default_nettype wire
